@@ rtl/tcb_pkg.sv @@
// Shared constants, command codes and types of the text console buffer engine.
package tcb_pkg;

    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    localparam logic [7:0] BLANK_CHAR    = 8'h20;
    localparam logic [7:0] NORMAL_RST    = 8'h0F;
    localparam logic [7:0] HIGHLIGHT_RST = 8'h30;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [0:0] REG_NORMAL    = 1'b0;
    localparam logic [0:0] REG_HIGHLIGHT = 1'b1;

    localparam logic [3:0] REQ_PUT      = 4'd0;
    localparam logic [3:0] REQ_WRITE_AT = 4'd1;
    localparam logic [3:0] REQ_SET_CUR  = 4'd2;
    localparam logic [3:0] REQ_READ     = 4'd3;
    localparam logic [3:0] REQ_NEWLINE  = 4'd4;
    localparam logic [3:0] REQ_BACK     = 4'd5;
    localparam logic [3:0] REQ_SELECT   = 4'd6;
    localparam logic [3:0] REQ_UNSELECT = 4'd7;
    localparam logic [3:0] REQ_CLEAR    = 4'd8;
    localparam logic [3:0] REQ_ADVANCE  = 4'd9;

    typedef struct packed {
        logic [7:0] normal_attr;
        logic [7:0] highlight_attr;
    } t_cfg;

endpackage

@@ rtl/tcb_regs.sv @@
// APB configuration registers: normal and highlight attributes.
module tcb_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tcb_pkg::PADDR_W-1:0]  paddr,
    input  logic [tcb_pkg::PDATA_W-1:0]  pwdata,
    output logic [tcb_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    output tcb_pkg::t_cfg                o_cfg
);

    logic [7:0] r_normal;
    logic [7:0] r_highlight;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_normal    <= tcb_pkg::NORMAL_RST;
            r_highlight <= tcb_pkg::HIGHLIGHT_RST;
        end else if (wr_en) begin
            unique case (paddr[2])
                tcb_pkg::REG_NORMAL:    r_normal    <= pwdata[7:0];
                tcb_pkg::REG_HIGHLIGHT: r_highlight <= pwdata[7:0];
                default:                r_normal    <= r_normal;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            tcb_pkg::REG_NORMAL:    prdata = {24'd0, r_normal};
            tcb_pkg::REG_HIGHLIGHT: prdata = {24'd0, r_highlight};
            default:                prdata = '0;
        endcase
    end

    assign o_cfg.normal_attr    = r_normal;
    assign o_cfg.highlight_attr = r_highlight;

endmodule

@@ rtl/text_console_buffer_engine.sv @@
// Text console buffer engine: character and attribute stores with a command sequencer.
// Cursor commands and single writes pass through EXEC and FIN before the result is registered; reads add RD.
// Select and unselect paint the range in the PAINT step, one attribute write per cycle.
// Clear fills every cell with a blank and the normal attribute; a scroll adds copy, flush and blank steps.
// A new command is taken only in idle, once the last has loaded its result; one waiting result does not block input.
// Reset: synchronous, active low; an INIT sweep over every cell zeroes both stores, stall high.
module text_console_buffer_engine #(
    parameter int COLUMNS = tcb_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcb_pkg::ROWS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tcb_pkg::PADDR_W-1:0]  paddr,
    input  logic [tcb_pkg::PDATA_W-1:0]  pwdata,
    output logic [tcb_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [3:0]                   i_req_type,
    input  logic [7:0]                   i_row,
    input  logic [7:0]                   i_col,
    input  logic [7:0]                   i_char_code,
    input  logic [7:0]                   i_end_row,
    input  logic [7:0]                   i_end_col,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [7:0]                   o_read_char,
    output logic                         o_read_valid,
    output logic [4:0]                   o_cur_row_out,
    output logic [6:0]                   o_cur_col_out
);

    localparam int CELLS = ROWS * COLUMNS;
    localparam int IW    = $clog2(CELLS);
    localparam int PW    = $clog2(255 * COLUMNS + 256);
    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLUMNS);
    localparam logic [RW-1:0] ROW_RST  = RW'((ROWS > 3) ? 3 : ROWS - 1);
    localparam logic [RW-1:0] ROW_LAST = RW'(ROWS - 1);
    localparam logic [CW-1:0] COL_LAST = CW'(COLUMNS - 1);
    localparam logic [IW-1:0] IDX_LAST = IW'(CELLS - 1);
    localparam logic [IW-1:0] CPY_LAST = IW'(CELLS - COLUMNS - 1);
    localparam logic [IW-1:0] BOT_ROW  = IW'(CELLS - COLUMNS);

    localparam logic [3:0] S_INIT   = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_EXEC   = 4'd2;
    localparam logic [3:0] S_RD     = 4'd3;
    localparam logic [3:0] S_PAINT  = 4'd4;
    localparam logic [3:0] S_CLR    = 4'd5;
    localparam logic [3:0] S_SCR    = 4'd6;
    localparam logic [3:0] S_SCR_FL = 4'd7;
    localparam logic [3:0] S_BLANK  = 4'd8;
    localparam logic [3:0] S_FIN    = 4'd9;

    tcb_pkg::t_cfg cfg;

    tcb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    logic [3:0]    r_state;
    logic [3:0]    r_req;
    logic [7:0]    r_row;
    logic [7:0]    r_col;
    logic [7:0]    r_ch;
    logic [7:0]    r_er;
    logic [7:0]    r_ec;
    logic [RW-1:0] r_cur_row;
    logic [CW-1:0] r_cur_col;
    logic [IW-1:0] r_idx;
    logic [IW-1:0] r_last;
    logic          r_wv;
    logic [IW-1:0] r_wa;
    logic [7:0]    r_res_char;
    logic          r_res_valid;
    logic          r_out_valid;
    logic [7:0]    r_out_char;
    logic          r_out_rv;
    logic [4:0]    r_out_row;
    logic [6:0]    r_out_col;

    logic [7:0] char_mem [CELLS];
    logic [7:0] attr_mem [CELLS];
    logic [7:0] char_q;
    logic [7:0] attr_q;

    logic          c_we;
    logic [IW-1:0] c_wa;
    logic [7:0]    c_wd;
    logic          a_we;
    logic [IW-1:0] a_wa;
    logic [7:0]    a_wd;
    logic          rd_en;
    logic [IW-1:0] rd_addr;

    logic          in_accept;
    logic          out_load;
    logic          in_rng;
    logic          at_last_col;
    logic          at_last_row;
    logic [IW-1:0] cur_idx;
    logic [IW-1:0] tgt_idx;
    logic [PW-1:0] pos_s;
    logic [PW-1:0] pos_e;
    logic [PW-1:0] pos_lim;

    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign out_load    = (r_state == S_FIN) && (!r_out_valid || !i_out_stall);

    assign in_rng      = ({1'b0, r_row} < 9'(ROWS)) && ({1'b0, r_col} < 9'(COLUMNS));
    assign at_last_col = (r_cur_col == COL_LAST);
    assign at_last_row = (r_cur_row == ROW_LAST);
    assign cur_idx     = IW'(r_cur_row) * IW'(COLUMNS) + IW'(r_cur_col);
    assign tgt_idx     = IW'(r_row) * IW'(COLUMNS) + IW'(r_col);
    assign pos_s       = PW'(r_row) * PW'(COLUMNS) + PW'(r_col);
    assign pos_e       = PW'(r_er) * PW'(COLUMNS) + PW'(r_ec);
    assign pos_lim     = (pos_e < PW'(CELLS)) ? pos_e : PW'(CELLS - 1);

    always_comb begin
        c_we    = 1'b0;
        c_wa    = r_idx;
        c_wd    = 8'd0;
        a_we    = 1'b0;
        a_wa    = r_idx;
        a_wd    = 8'd0;
        rd_en   = 1'b0;
        rd_addr = r_idx + IW'(COLUMNS);
        unique case (r_state)
            S_INIT: begin
                c_we = 1'b1;
                a_we = 1'b1;
            end
            S_EXEC: begin
                if (r_req == tcb_pkg::REQ_PUT) begin
                    c_we = 1'b1;
                    c_wa = cur_idx;
                    c_wd = r_ch;
                end else if (r_req == tcb_pkg::REQ_WRITE_AT) begin
                    c_we = in_rng;
                    c_wa = tgt_idx;
                    c_wd = r_ch;
                end else if (r_req == tcb_pkg::REQ_READ) begin
                    rd_en   = in_rng;
                    rd_addr = tgt_idx;
                end
            end
            S_PAINT: begin
                a_we = 1'b1;
                a_wd = (r_req == tcb_pkg::REQ_SELECT) ? cfg.highlight_attr
                                                      : cfg.normal_attr;
            end
            S_CLR: begin
                c_we = 1'b1;
                c_wd = tcb_pkg::BLANK_CHAR;
                a_we = 1'b1;
                a_wd = cfg.normal_attr;
            end
            S_SCR, S_SCR_FL: begin
                rd_en = (r_state == S_SCR);
                c_we  = r_wv || (r_state == S_SCR_FL);
                c_wa  = r_wa;
                c_wd  = char_q;
                a_we  = c_we;
                a_wa  = r_wa;
                a_wd  = attr_q;
            end
            S_BLANK: begin
                c_we = 1'b1;
                c_wd = tcb_pkg::BLANK_CHAR;
            end
            default: begin
                c_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (c_we) begin
            char_mem[c_wa] <= c_wd;
        end
        if (a_we) begin
            attr_mem[a_wa] <= a_wd;
        end
        if (rd_en) begin
            char_q <= char_mem[rd_addr];
            attr_q <= attr_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_req <= i_req_type;
            r_row <= i_row;
            r_col <= i_col;
            r_ch  <= i_char_code;
            r_er  <= i_end_row;
            r_ec  <= i_end_col;
        end
        if (out_load) begin
            r_out_char <= r_res_char;
            r_out_rv   <= r_res_valid;
            r_out_row  <= 5'(r_cur_row);
            r_out_col  <= 7'(r_cur_col);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_cur_row   <= ROW_RST;
            r_cur_col   <= '0;
            r_idx       <= '0;
            r_last      <= '0;
            r_wv        <= 1'b0;
            r_wa        <= '0;
            r_res_char  <= 8'd0;
            r_res_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= out_load || (r_out_valid && i_out_stall);
            unique case (r_state)
                S_INIT: begin
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == IDX_LAST) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_accept) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_res_char  <= 8'd0;
                    r_res_valid <= (r_req == tcb_pkg::REQ_READ) && in_rng;
                    r_wv        <= 1'b0;
                    r_idx       <= ((r_req == tcb_pkg::REQ_SELECT) ||
                                    (r_req == tcb_pkg::REQ_UNSELECT)) ? IW'(pos_s) : '0;
                    unique case (r_req)
                        tcb_pkg::REQ_PUT, tcb_pkg::REQ_ADVANCE: begin
                            if (!at_last_col) begin
                                r_cur_col <= r_cur_col + 1'b1;
                                r_state   <= S_FIN;
                            end else if (!at_last_row) begin
                                r_cur_row <= r_cur_row + 1'b1;
                                r_cur_col <= '0;
                                r_state   <= S_FIN;
                            end else begin
                                r_state <= (r_req == tcb_pkg::REQ_PUT) ? S_SCR : S_FIN;
                            end
                        end
                        tcb_pkg::REQ_SET_CUR: begin
                            if (in_rng) begin
                                r_cur_row <= RW'(r_row);
                                r_cur_col <= CW'(r_col);
                            end
                            r_state <= S_FIN;
                        end
                        tcb_pkg::REQ_READ: begin
                            r_state <= S_RD;
                        end
                        tcb_pkg::REQ_NEWLINE: begin
                            if (at_last_row) begin
                                r_state <= S_SCR;
                            end else begin
                                r_cur_row <= r_cur_row + 1'b1;
                                r_cur_col <= '0;
                                r_state   <= S_FIN;
                            end
                        end
                        tcb_pkg::REQ_BACK: begin
                            if (r_cur_col != '0) begin
                                r_cur_col <= r_cur_col - 1'b1;
                            end else if (r_cur_row != '0) begin
                                r_cur_row <= r_cur_row - 1'b1;
                                r_cur_col <= COL_LAST;
                            end
                            r_state <= S_FIN;
                        end
                        tcb_pkg::REQ_SELECT, tcb_pkg::REQ_UNSELECT: begin
                            r_last  <= IW'(pos_lim);
                            r_state <= ((pos_s <= pos_e) && (pos_s < PW'(CELLS))) ? S_PAINT
                                                                                   : S_FIN;
                        end
                        tcb_pkg::REQ_CLEAR: begin
                            r_state <= S_CLR;
                        end
                        default: begin
                            r_state <= S_FIN;
                        end
                    endcase
                end
                S_RD: begin
                    if (r_res_valid) begin
                        r_res_char <= char_q;
                    end
                    r_state <= S_FIN;
                end
                S_PAINT: begin
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == r_last) begin
                        r_state <= S_FIN;
                    end
                end
                S_CLR: begin
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == IDX_LAST) begin
                        r_state <= S_FIN;
                    end
                end
                S_SCR: begin
                    r_wv  <= 1'b1;
                    r_wa  <= r_idx;
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == CPY_LAST) begin
                        r_state <= S_SCR_FL;
                    end
                end
                S_SCR_FL: begin
                    r_wv    <= 1'b0;
                    r_idx   <= BOT_ROW;
                    r_state <= S_BLANK;
                end
                S_BLANK: begin
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == IDX_LAST) begin
                        r_cur_row <= ROW_LAST;
                        r_cur_col <= '0;
                        r_state   <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_read_char   = r_out_char;
    assign o_read_valid  = r_out_rv;
    assign o_cur_row_out = r_out_row;
    assign o_cur_col_out = r_out_col;

    a_cursor_on_screen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (int'(r_cur_row) < ROWS) && (int'(r_cur_col) < COLUMNS))
        else $error("cursor left the screen");

    a_result_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_FIN))
        else $error("result loaded outside the finish step");

    a_paint_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PAINT) |-> (r_idx <= r_last))
        else $error("paint index ran past the range end");

    a_copy_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCR && r_wv) |-> (r_wa != rd_addr))
        else $error("scroll copy reads the entry it writes");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |-> ($past(r_state) == S_IDLE))
        else $error("command started outside idle");

endmodule
